[src/lfu_pkg.sv]
package lfu_pkg;

   localparam int ADDR_W = 48;
   localparam int PAGE_W = 34;
   localparam int COUNT_W = 32;
   localparam int STAMP_W = 64;
   localparam int CAP_W = 7;
   localparam int KEY_W = COUNT_W + STAMP_W;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int PAGE_SHIFT_DEFAULT = 14;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;

   // result codes
   localparam logic [1:0] OUT_HIT = 2'd0;
   localparam logic [1:0] OUT_MISS_FREE = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE
   } lfu_state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic update;
   } lfu_cmd_type;

   typedef struct packed {
      logic scan_last;
   } lfu_status_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [COUNT_W-1:0] count;
      logic [STAMP_W-1:0] stamp;
   } lfu_entry_type;

endpackage

[src/lfu_ctrl.sv]
module lfu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output lfu_pkg::lfu_cmd_type    cmd,
   input  lfu_pkg::lfu_status_type status
);
   import lfu_pkg::*;

   lfu_state_type state_ff;
   lfu_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last read still in flight
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_update_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff == ST_IDLE))
      else $error("update did not return to idle");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_SCAN))
      else $error("accepted beat did not start a scan");

   a_drain_updates: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> (state_ff == ST_UPDATE))
      else $error("drain did not lead to the update");

endmodule

[src/lfu_dpath.sv]
module lfu_dpath #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT,
   parameter int PAGE_SHIFT = lfu_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfu_pkg::lfu_cmd_type           cmd,
   output lfu_pkg::lfu_status_type        status,
   input  logic [lfu_pkg::ADDR_W-1:0]    req_access_address,
   input  logic [lfu_pkg::CAP_W-1:0]     capacity,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_outcome,
   output logic [lfu_pkg::PAGE_W-1:0]    rsp_victim_page
);
   import lfu_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   lfu_entry_type mem [ENTRIES];
   lfu_entry_type rd_data_ff;

   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_pend_ff, rd_pend_in;
   logic               hit_found_ff, hit_found_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               vic_found_ff, vic_found_in;
   logic [IDX_W-1:0]   vic_idx_ff, vic_idx_in;
   logic [KEY_W-1:0]   vic_key_ff, vic_key_in;
   logic [PAGE_W-1:0]  vic_page_ff, vic_page_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   resident_ff, resident_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_outcome_ff, rsp_outcome_in;
   logic [PAGE_W-1:0]  rsp_page_ff, rsp_page_in;

   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               has_room;
   logic               rd_valid;
   logic [KEY_W-1:0]   rd_key;
   logic [IDX_W-1:0]   wr_idx;
   lfu_entry_type      wr_entry;

   assign status.scan_last = (scan_idx_ff == LAST_IDX);

   // capacity clamped to 1..ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity);
      priority if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign has_room = (CMP_W'(resident_ff) < eff_cap);
   assign rd_valid = valid_ff[rd_idx_ff];
   assign rd_key = {rd_data_ff.count, rd_data_ff.stamp};

   always_comb begin
      page_in = page_ff;
      scan_idx_in = scan_idx_ff;
      rd_pend_in = cmd.scan;
      hit_found_in = hit_found_ff;
      hit_idx_in = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_found_in = free_found_ff;
      free_idx_in = free_idx_ff;
      vic_found_in = vic_found_ff;
      vic_idx_in = vic_idx_ff;
      vic_key_in = vic_key_ff;
      vic_page_in = vic_page_ff;
      valid_in = valid_ff;
      resident_in = resident_ff;
      stamp_in = stamp_ff;
      rsp_strobe_in = 1'b0;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_page_in = rsp_page_ff;
      wr_idx = '0;
      wr_entry.page = page_ff;
      wr_entry.count = COUNT_ONE;
      wr_entry.stamp = stamp_ff;

      if (cmd.load) begin
         page_in = PAGE_W'(req_access_address >> PAGE_SHIFT);
         scan_idx_in = '0;
         hit_found_in = 1'b0;
         free_found_in = 1'b0;
         vic_found_in = 1'b0;
      end

      if (cmd.scan) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end

      // one entry per cycle, read data from the previous cycle
      if (rd_pend_ff) begin
         if (rd_valid) begin
            if (rd_data_ff.page == page_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in = rd_idx_ff;
               hit_count_in = rd_data_ff.count;
            end
            if (!vic_found_ff || (rd_key < vic_key_ff)) begin
               vic_found_in = 1'b1;
               vic_idx_in = rd_idx_ff;
               vic_key_in = rd_key;
               vic_page_in = rd_data_ff.page;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end

      if (cmd.update) begin
         rsp_strobe_in = 1'b1;
         stamp_in = stamp_ff + STAMP_W'(1);
         priority if (hit_found_ff) begin
            wr_idx = hit_idx_ff;
            wr_entry.count = (hit_count_ff == COUNT_MAX) ? hit_count_ff
                                                         : hit_count_ff + COUNT_ONE;
            rsp_outcome_in = OUT_HIT;
            rsp_page_in = '0;
         end else if (has_room && free_found_ff) begin
            wr_idx = free_idx_ff;
            resident_in = resident_ff + CNT_W'(1);
            rsp_outcome_in = OUT_MISS_FREE;
            rsp_page_in = '0;
         end else begin
            wr_idx = vic_found_ff ? vic_idx_ff : '0;
            rsp_outcome_in = OUT_EVICT;
            rsp_page_in = vic_found_ff ? vic_page_ff : '0;
         end
         valid_in[wr_idx] = 1'b1;
      end
   end

   // table storage, single read port swept by the scan
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         mem[wr_idx] <= wr_entry;
      end
      if (cmd.scan) begin
         rd_data_ff <= mem[scan_idx_ff];
         rd_idx_ff <= scan_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         hit_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         vic_found_ff <= 1'b0;
         valid_ff <= '0;
         resident_ff <= '0;
         stamp_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         rd_pend_ff <= rd_pend_in;
         hit_found_ff <= hit_found_in;
         free_found_ff <= free_found_in;
         vic_found_ff <= vic_found_in;
         valid_ff <= valid_in;
         resident_ff <= resident_in;
         stamp_ff <= stamp_in;
         rsp_strobe_ff <= rsp_strobe_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      hit_idx_ff <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff <= free_idx_in;
      vic_idx_ff <= vic_idx_in;
      vic_key_ff <= vic_key_in;
      vic_page_ff <= vic_page_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_page_ff <= rsp_page_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_victim_page = rsp_page_ff;

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.update))
      else $error("result beat without an update");

   a_resident_bound: assert property (@(posedge clock) disable iff (reset)
      resident_ff <= CNT_W'(ENTRIES))
      else $error("resident count above table size");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_outcome_ff == OUT_MISS_FREE)
         |-> (resident_ff == $past(resident_ff) + CNT_W'(1)))
      else $error("free-frame insert did not grow resident count");

endmodule

[src/lfu_page_replacement.sv]
// channel   ports                                    beat moves on
// request   start, busy, req_access_address         start high and busy low
// result    rsp_strobe, rsp_outcome, rsp_victim_page each cycle rsp_strobe is high
// config    psel, penable, pwrite, paddr, pwdata    psel, penable, pwrite, pready high
//
// an item runs through scan over every entry, drain and update; busy holds off the next until back in idle
// the scan reads one table entry per cycle through the single memory read port
// the result beat shows in the cycle after the table update, while busy is already low
// reset clears valid bits, resident count and stamp at once, no clearing pass
// the result side cannot stall; every result is shown for exactly one cycle
module lfu_page_replacement #(
   parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT,
   parameter int PAGE_SHIFT = lfu_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [lfu_pkg::ADDR_W-1:0]        req_access_address,
   output logic                              rsp_strobe,
   output logic [1:0]                        rsp_outcome,
   output logic [lfu_pkg::PAGE_W-1:0]        rsp_victim_page,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lfu_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lfu_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lfu_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import lfu_pkg::*;

   lfu_cmd_type    cmd;
   lfu_status_type status;

   logic [CAP_W-1:0] capacity_ff, capacity_in;
   logic             reg_sel;

   assign pready = 1'b1;
   assign reg_sel = (paddr[CSR_ADDR_W-1] == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (psel && penable && pwrite && pready && reg_sel) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = reg_sel ? CSR_DATA_W'(capacity_ff) : '0;

   lfu_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   lfu_dpath #(
      .ENTRIES    (ENTRIES),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_access_address (req_access_address),
      .capacity           (capacity_ff),
      .rsp_strobe         (rsp_strobe),
      .rsp_outcome        (rsp_outcome),
      .rsp_victim_page    (rsp_victim_page)
   );

endmodule
